// ===== src/bb3_pkg.sv =====
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 13;
  localparam int CFGW_W = 11;
  localparam int CFGH_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFGW_W-1:0] WIDTH_RESET  = CFGW_W'(640);
  localparam logic [CFGH_W-1:0] HEIGHT_RESET = CFGH_W'(480);

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = CFG_ADDR_W'(1);

  localparam int SUM_W       = 12;
  localparam int N_W         = 4;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic flush;
    logic row_end;
    logic rc_ge1;
    logic rc_ge2;
    logic c_ge1;
    logic c_ge2;
  } flag_t;

  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] addr;
    pix_t             cur;
    flag_t            flags;
  } req_t;

  typedef struct packed {
    logic  vld;
    flag_t flags;
  } tag_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  typedef struct packed {
    logic           vld;
    logic           va;
    logic           vb;
    logic           fe;
    sum_t           sa;
    sum_t           sb;
    logic [N_W-1:0] na;
    logic [N_W-1:0] nb;
  } acc_t;

  // Scaled reciprocal of 2n, rounded up; exact for every numerator that can occur.
  function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      N_W'(1): r = RECIP_W'(131072);
      N_W'(2): r = RECIP_W'(65536);
      N_W'(3): r = RECIP_W'(43691);
      N_W'(4): r = RECIP_W'(32768);
      N_W'(6): r = RECIP_W'(21846);
      N_W'(9): r = RECIP_W'(14564);
      default: r = RECIP_W'(131072);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/bb3_ctrl.sv =====
`default_nettype none

module bb3_ctrl (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [bb3_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [bb3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                             in_tvalid,
  input  wire                             in_tuser,
  input  wire [23:0]                      in_tdata,
  input  wire                             adv,
  output logic                            in_tready,
  output bb3_pkg::req_t                   req
);

  logic [bb3_pkg::CFGW_W-1:0] width_r;
  logic [bb3_pkg::CFGH_W-1:0] height_r;
  logic [bb3_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [bb3_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [bb3_pkg::CFGW_W-1:0] w_eff;
  logic [bb3_pkg::CFGH_W-1:0] h_eff;
  logic                       flush, row_end, skip, take;

  always_comb begin
    if (width_r == '0) begin
      w_eff = bb3_pkg::CFGW_W'(1);
    end else if (width_r > bb3_pkg::CFGW_W'(bb3_pkg::MAX_WIDTH)) begin
      w_eff = bb3_pkg::CFGW_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = bb3_pkg::CFGH_W'(1);
    end else if (height_r > bb3_pkg::CFGH_W'(bb3_pkg::MAX_HEIGHT)) begin
      h_eff = bb3_pkg::CFGH_W'(bb3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign flush   = (row_r >= h_eff);
  assign row_end = ({1'b0, col_r} >= (w_eff - bb3_pkg::CFGW_W'(1)));
  assign skip    = in_tuser && !flush;
  assign in_tready = adv && rst_n;
  assign take    = in_tvalid && in_tready && !skip;

  always_comb begin
    req.vld           = in_tvalid && !skip;
    req.addr          = col_r;
    req.cur.red       = flush ? 8'd0 : in_tdata[7:0];
    req.cur.green     = flush ? 8'd0 : in_tdata[15:8];
    req.cur.blue      = flush ? 8'd0 : in_tdata[23:16];
    req.flags.flush   = flush;
    req.flags.row_end = row_end;
    req.flags.rc_ge1  = (row_r != '0);
    req.flags.rc_ge2  = (row_r >= bb3_pkg::ROW_W'(2));
    req.flags.c_ge1   = (col_r != '0);
    req.flags.c_ge2   = (col_r >= bb3_pkg::COL_W'(2));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = flush ? '0 : row_r + bb3_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + bb3_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bb3_pkg::WIDTH_RESET;
      height_r <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        bb3_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata[bb3_pkg::CFGW_W-1:0];
        bb3_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata[bb3_pkg::CFGH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bb3_line_buf.sv =====
`default_nettype none

module bb3_line_buf (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            adv,
  input  bb3_pkg::req_t  req,
  output bb3_pkg::win_t  win,
  output bb3_pkg::tag_t  tag
);

  bb3_pkg::pix_t near_mem [bb3_pkg::MAX_WIDTH];
  bb3_pkg::pix_t far_mem  [bb3_pkg::MAX_WIDTH];

  bb3_pkg::req_t p1_r;
  logic          fwd_r;
  bb3_pkg::pix_t rd_near_r, rd_far_r;
  bb3_pkg::pix_t last_cur_r, last_near_r;
  bb3_pkg::pix_t near_eff, far_eff;
  bb3_pkg::win_t win_r;
  bb3_pkg::tag_t tag_r;

  // A read issued while the previous item writes the same entry sees the old
  // data, so that item's write data is forwarded instead.
  assign near_eff = fwd_r ? last_cur_r  : rd_near_r;
  assign far_eff  = fwd_r ? last_near_r : rd_far_r;

  always_ff @(posedge clk) begin
    if (adv && req.vld) begin
      rd_near_r <= near_mem[req.addr];
    end
    if (adv && p1_r.vld) begin
      near_mem[p1_r.addr] <= p1_r.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req.vld) begin
      rd_far_r <= far_mem[req.addr];
    end
    if (adv && p1_r.vld) begin
      far_mem[p1_r.addr] <= near_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p1_r.vld) begin
      last_cur_r  <= p1_r.cur;
      last_near_r <= near_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r  <= '0;
      fwd_r <= 1'b0;
      tag_r <= '0;
    end else if (adv) begin
      p1_r  <= req;
      fwd_r <= p1_r.vld && req.vld && (p1_r.addr == req.addr);
      tag_r <= '{vld: p1_r.vld, flags: p1_r.flags};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv && p1_r.vld) begin
      win_r[5:0] <= win_r[8:3];
      win_r[6]   <= far_eff;
      win_r[7]   <= near_eff;
      win_r[8]   <= p1_r.cur;
    end
  end

  assign win = win_r;
  assign tag = tag_r;

endmodule

`default_nettype wire

// ===== src/bb3_mean.sv =====
`default_nettype none

module bb3_mean (
  input  wire            clk,
  input  wire            rst_n,
  input  bb3_pkg::win_t  win,
  input  bb3_pkg::tag_t  tag,
  input  wire            out_tready,
  output logic           adv,
  output logic           out_valid,
  output bb3_pkg::pix_t  out_pix,
  output logic           frame_end,
  output logic           run_last
);

  function automatic bb3_pkg::sum_t col_sum(input bb3_pkg::pix_t t, input bb3_pkg::pix_t m,
                                            input bb3_pkg::pix_t b, input logic t_en,
                                            input logic b_en);
    bb3_pkg::sum_t s;
    s.red   = bb3_pkg::SUM_W'(m.red)   + (t_en ? bb3_pkg::SUM_W'(t.red)   : '0)
            + (b_en ? bb3_pkg::SUM_W'(b.red)   : '0);
    s.green = bb3_pkg::SUM_W'(m.green) + (t_en ? bb3_pkg::SUM_W'(t.green) : '0)
            + (b_en ? bb3_pkg::SUM_W'(b.green) : '0);
    s.blue  = bb3_pkg::SUM_W'(m.blue)  + (t_en ? bb3_pkg::SUM_W'(t.blue)  : '0)
            + (b_en ? bb3_pkg::SUM_W'(b.blue)  : '0);
    return s;
  endfunction

  function automatic logic [7:0] mean_of(input logic [bb3_pkg::SUM_W-1:0] s,
                                         input logic [bb3_pkg::N_W-1:0] n);
    logic [bb3_pkg::SUM_W:0]                  x;
    logic [bb3_pkg::SUM_W+bb3_pkg::RECIP_W:0] p;
    x = {s, 1'b0} + (bb3_pkg::SUM_W+1)'(n);
    p = (bb3_pkg::SUM_W+bb3_pkg::RECIP_W+1)'(x)
      * (bb3_pkg::SUM_W+bb3_pkg::RECIP_W+1)'(bb3_pkg::recip(n));
    return p[bb3_pkg::RECIP_SHIFT+7:bb3_pkg::RECIP_SHIFT];
  endfunction

  bb3_pkg::sum_t  c0, c1, c2;
  bb3_pkg::acc_t  acc_nxt, p3_r;
  logic [1:0]     nrows, ncols_a, ncols_b;
  logic           t_en, b_en;
  bb3_pkg::pix_t  mean_a, mean_b;
  bb3_pkg::pix_t  out_a_r, out_b_r;
  logic           va_r, vb_r, fe_r;

  assign t_en = tag.flags.rc_ge2;
  assign b_en = !tag.flags.flush;

  assign c0 = col_sum(win[0], win[1], win[2], t_en, b_en);
  assign c1 = col_sum(win[3], win[4], win[5], t_en, b_en);
  assign c2 = col_sum(win[6], win[7], win[8], t_en, b_en);

  always_comb begin
    nrows   = 2'd1 + {1'b0, t_en} + {1'b0, b_en};
    ncols_a = tag.flags.c_ge2 ? 2'd3 : 2'd2;
    ncols_b = tag.flags.c_ge1 ? 2'd2 : 2'd1;

    acc_nxt.vld = tag.vld;
    acc_nxt.va  = tag.flags.rc_ge1 && tag.flags.c_ge1;
    acc_nxt.vb  = tag.flags.rc_ge1 && tag.flags.row_end;
    acc_nxt.fe  = tag.flags.flush;

    acc_nxt.sa.red   = (tag.flags.c_ge2 ? c0.red   : '0) + c1.red   + c2.red;
    acc_nxt.sa.green = (tag.flags.c_ge2 ? c0.green : '0) + c1.green + c2.green;
    acc_nxt.sa.blue  = (tag.flags.c_ge2 ? c0.blue  : '0) + c1.blue  + c2.blue;
    acc_nxt.sb.red   = (tag.flags.c_ge1 ? c1.red   : '0) + c2.red;
    acc_nxt.sb.green = (tag.flags.c_ge1 ? c1.green : '0) + c2.green;
    acc_nxt.sb.blue  = (tag.flags.c_ge1 ? c1.blue  : '0) + c2.blue;

    acc_nxt.na = {2'b00, nrows} * {2'b00, ncols_a};
    acc_nxt.nb = {2'b00, nrows} * {2'b00, ncols_b};
  end

  assign mean_a.red   = mean_of(p3_r.sa.red,   p3_r.na);
  assign mean_a.green = mean_of(p3_r.sa.green, p3_r.na);
  assign mean_a.blue  = mean_of(p3_r.sa.blue,  p3_r.na);
  assign mean_b.red   = mean_of(p3_r.sb.red,   p3_r.nb);
  assign mean_b.green = mean_of(p3_r.sb.green, p3_r.nb);
  assign mean_b.blue  = mean_of(p3_r.sb.blue,  p3_r.nb);

  // The pipeline moves unless the output register still holds a result that
  // will not leave this cycle.
  assign adv = !(va_r || vb_r) || (out_tready && (va_r ^ vb_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_r <= '0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      fe_r <= 1'b0;
    end else if (adv) begin
      p3_r <= acc_nxt;
      va_r <= p3_r.vld && p3_r.va;
      vb_r <= p3_r.vld && p3_r.vb;
      fe_r <= p3_r.fe;
    end else if (out_tready && va_r) begin
      va_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_a_r <= mean_a;
      out_b_r <= mean_b;
    end
  end

  assign out_valid = va_r || vb_r;
  assign out_pix   = va_r ? out_a_r : out_b_r;
  assign run_last  = !(va_r && vb_r);
  assign frame_end = !va_r && fe_r;

endmodule

`default_nettype wire

// ===== src/box_blur_3x3.sv =====
// 3x3 box blur over an RGB pixel stream in raster order.
// Input transactions carry one pixel in in_tdata (red, green, blue from bit 0 up);
// in_tuser set outside the flush discards that transfer. After the last row of a frame the host sends
// one flush step per column to drain the final row. Results leave on the out_
// channel with the same channel order; out_tlast flags the frame's final pixel
// and out_tuser the last result caused by one input transaction.
// The result for pixel (r, c) is produced by input (r+1, c+1); the last input
// of a row also produces the result for its own column of the row above.
// An accepted input passes through the line buffer read, window update,
// neighborhood sums, and the reciprocal multiply into the output register
// before its first result reaches the port. Throughput is one input per cycle
// while out_tready is high. An input that ends a row after the first yields
// two results (one if the width is 1), which leave in turn through the single
// output register, so in_tready drops for one cycle behind it.
// Image size is written through the cfg_ port while the block is idle.
// Reset clears counters, window and pipeline; the line buffers need no clearing.
// When out_tready is low while a result is held, the output register holds and
// the pipeline, and with it in_tready, stops.

`default_nettype none

module box_blur_3x3 (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [bb3_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [bb3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [23:0]                      in_tdata,   // red, green, blue
  input  wire                             in_tuser,   // mode
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [23:0]                     out_tdata,  // red_out, green_out, blue_out
  output logic                            out_tlast,
  output logic                            out_tuser   // run_last
);

  bb3_pkg::req_t req;
  bb3_pkg::win_t win;
  bb3_pkg::tag_t tag;
  bb3_pkg::pix_t out_pix;
  logic          adv;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .in_tready (in_tready),
    .req       (req)
  );

  bb3_line_buf u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (req),
    .win   (win),
    .tag   (tag)
  );

  bb3_mean u_mean (
    .clk        (clk),
    .rst_n      (rst_n),
    .win        (win),
    .tag        (tag),
    .out_tready (out_tready),
    .adv        (adv),
    .out_valid  (out_tvalid),
    .out_pix    (out_pix),
    .frame_end  (out_tlast),
    .run_last   (out_tuser)
  );

  assign out_tdata = {out_pix.blue, out_pix.green, out_pix.red};

endmodule

`default_nettype wire

// ===== src/bb3_check.sv =====
`default_nettype none

module bb3_check (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           cfg_we,
  input wire [bb3_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input wire [bb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input wire                           in_tvalid,
  input wire                           in_tready,
  input wire [23:0]                    in_tdata,
  input wire                           in_tuser,
  input wire                           out_tvalid,
  input wire                           out_tready,
  input wire [23:0]                    out_tdata,
  input wire                           out_tlast,
  input wire                           out_tuser
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                   && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser |=> out_tvalid)
    else $error("second result of a transaction missing");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end on a result that is not the last of its transaction");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output register");

endmodule

bind box_blur_3x3 bb3_check u_bb3_check (.*);

`default_nettype wire
